@@ rtl/core/ssdf_pkg.sv @@
// Package for the sign-split dual FIFO: field widths, opcode and status codes, defaults.
package ssdf_pkg;

    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int DATA_WIDTH_DEF  = 32;

    localparam int VALUE_W  = 32;
    localparam int OPCODE_W = 2;
    localparam int STATUS_W = 2;

    // s_tuser: opcode; m_tuser: status, nonneg_empty, neg_empty
    localparam int S_TUSER_W = OPCODE_W;
    localparam int M_TUSER_W = STATUS_W + 2;

    typedef logic [OPCODE_W-1:0] opcode_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam opcode_t OP_PUSH       = 2'd0;
    localparam opcode_t OP_POP_NONNEG = 2'd1;
    localparam opcode_t OP_POP_NEG    = 2'd2;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_EMPTY = 2'd2;

endpackage

@@ rtl/core/ssdf_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered read data.
module ssdf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // read data holds until the next read
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/core/sign_split_dual_fifo.sv @@
// Top level of the sign-split dual FIFO: two circular queues held in RAM, split by sign.
//
// A push beat (opcode push) steers its value to the non-negative queue (zero
// included) or to the negative queue, chosen by bit 31 of the value; a push
// into a full queue is dropped and reported with status "full". A pop beat
// names one queue and returns its oldest entry, or status "empty" and data 0.
// Opcode 3 does nothing and returns status ok, data 0. Every input beat makes
// exactly one output beat, which also carries both empty flags as they stand
// after that beat. Each queue lives in its own RAM with a registered read; head,
// tail and count sit in flops, so full/empty are known the cycle a beat arrives.
// Unless the output stalls, the block takes one beat per clock: an accepted beat
// shows up on the output in the next cycle, and a new beat is taken in the same
// cycle the pending result is taken. Popped data comes straight off the RAM read
// register, which only reloads on the next accepted pop, so a stalled result
// holds. A push and a pop never touch the same entry in one cycle, since one
// beat does one operation and a pop only reads entries written earlier.
// Entries keep the low DATA_WIDTH bits of the value and are sign-extended (or
// truncated) back to 32 bits on the way out. No clearing pass after reset.
module sign_split_dual_fifo
    import ssdf_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int DATA_WIDTH  = DATA_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [VALUE_W-1:0]   s_tdata,   // [31:0] value
    input  logic [S_TUSER_W-1:0] s_tuser,   // [1:0] opcode
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [VALUE_W-1:0]   m_tdata,   // [31:0] data
    output logic [M_TUSER_W-1:0] m_tuser    // [1:0] status, [2] nonneg_empty, [3] neg_empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    // queue pointers and occupancy
    logic [PTR_W-1:0] nn_head_reg, nn_head_next, nn_tail_reg, nn_tail_next;
    logic [PTR_W-1:0] ng_head_reg, ng_head_next, ng_tail_reg, ng_tail_next;
    logic [CNT_W-1:0] nn_count_reg, nn_count_next, ng_count_reg, ng_count_next;

    // output beat
    logic    out_valid_reg, out_valid_next;
    status_t status_reg, status_next;
    logic    pop_ok_reg, pop_ok_next;
    logic    sel_neg_reg, sel_neg_next;
    logic    nn_empty_reg, ng_empty_reg;

    logic             accept;
    opcode_t          opcode;
    logic             nn_full, ng_full;
    logic             nn_we, ng_we, nn_re, ng_re;
    logic [DATA_WIDTH-1:0] wr_data, nn_rdata, ng_rdata, rd_word;
    logic [VALUE_W-1:0]    pop_data;

    assign opcode   = s_tuser;
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign nn_full  = (nn_count_reg == CNT_FULL);
    assign ng_full  = (ng_count_reg == CNT_FULL);
    assign wr_data  = DATA_WIDTH'(s_tdata);

    always_comb
    begin
        nn_head_next  = nn_head_reg;
        nn_tail_next  = nn_tail_reg;
        nn_count_next = nn_count_reg;
        ng_head_next  = ng_head_reg;
        ng_tail_next  = ng_tail_reg;
        ng_count_next = ng_count_reg;
        status_next   = ST_OK;
        pop_ok_next   = 1'b0;
        sel_neg_next  = 1'b0;
        nn_we = 1'b0;
        ng_we = 1'b0;
        nn_re = 1'b0;
        ng_re = 1'b0;
        if (accept)
        begin
            case (opcode)
                OP_PUSH:
                begin
                    if (s_tdata[VALUE_W-1])
                    begin
                        if (ng_full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            ng_we         = 1'b1;
                            ng_tail_next  = (ng_tail_reg == PTR_LAST) ? '0 : ng_tail_reg + 1'b1;
                            ng_count_next = ng_count_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        if (nn_full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            nn_we         = 1'b1;
                            nn_tail_next  = (nn_tail_reg == PTR_LAST) ? '0 : nn_tail_reg + 1'b1;
                            nn_count_next = nn_count_reg + 1'b1;
                        end
                    end
                end
                OP_POP_NONNEG:
                begin
                    if (nn_count_reg == '0)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        nn_re         = 1'b1;
                        pop_ok_next   = 1'b1;
                        nn_head_next  = (nn_head_reg == PTR_LAST) ? '0 : nn_head_reg + 1'b1;
                        nn_count_next = nn_count_reg - 1'b1;
                    end
                end
                OP_POP_NEG:
                begin
                    sel_neg_next = 1'b1;
                    if (ng_count_reg == '0)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        ng_re         = 1'b1;
                        pop_ok_next   = 1'b1;
                        ng_head_next  = (ng_head_reg == PTR_LAST) ? '0 : ng_head_reg + 1'b1;
                        ng_count_next = ng_count_reg - 1'b1;
                    end
                end
                default:
                begin
                    // no-op opcode
                end
            endcase
        end
    end

    assign out_valid_next = accept ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nn_head_reg   <= '0;
            nn_tail_reg   <= '0;
            nn_count_reg  <= '0;
            ng_head_reg   <= '0;
            ng_tail_reg   <= '0;
            ng_count_reg  <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= ST_OK;
            pop_ok_reg    <= 1'b0;
            sel_neg_reg   <= 1'b0;
            nn_empty_reg  <= 1'b1;
            ng_empty_reg  <= 1'b1;
        end
        else
        begin
            nn_head_reg   <= nn_head_next;
            nn_tail_reg   <= nn_tail_next;
            nn_count_reg  <= nn_count_next;
            ng_head_reg   <= ng_head_next;
            ng_tail_reg   <= ng_tail_next;
            ng_count_reg  <= ng_count_next;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                status_reg   <= status_next;
                pop_ok_reg   <= pop_ok_next;
                sel_neg_reg  <= sel_neg_next;
                nn_empty_reg <= (nn_count_next == '0);
                ng_empty_reg <= (ng_count_next == '0);
            end
        end
    end

    ssdf_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (QUEUE_DEPTH)
    ) u_nonneg_ram (
        .clk   (clk),
        .we    (nn_we),
        .waddr (nn_tail_reg),
        .wdata (wr_data),
        .re    (nn_re),
        .raddr (nn_head_reg),
        .rdata (nn_rdata)
    );

    ssdf_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (QUEUE_DEPTH)
    ) u_neg_ram (
        .clk   (clk),
        .we    (ng_we),
        .waddr (ng_tail_reg),
        .wdata (wr_data),
        .re    (ng_re),
        .raddr (ng_head_reg),
        .rdata (ng_rdata)
    );

    assign rd_word = sel_neg_reg ? ng_rdata : nn_rdata;

    // back to the 32-bit field: sign-extend narrow entries, drop upper zeros of wide ones
    generate
        if (DATA_WIDTH >= VALUE_W)
        begin : g_wide
            assign pop_data = rd_word[VALUE_W-1:0];
        end
        else
        begin : g_narrow
            assign pop_data = VALUE_W'($signed(rd_word));
        end
    endgenerate

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = pop_ok_reg ? pop_data : '0;
    assign m_tuser  = {ng_empty_reg, nn_empty_reg, status_reg};

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (nn_count_reg <= CNT_FULL) && (ng_count_reg <= CNT_FULL))
        else $error("queue count above depth");

    a_pop_ok_status: assert property (@(posedge clk) disable iff (!rst_n)
        pop_ok_reg |-> (status_reg == ST_OK))
        else $error("returned data with non-ok status");

    a_empty_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((nn_empty_reg == (nn_count_reg == '0))
                        && (ng_empty_reg == (ng_count_reg == '0))))
        else $error("empty flags disagree with counts");

    a_full_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (status_next == ST_FULL)) |=>
            ($stable(nn_count_reg) && $stable(ng_count_reg)
             && $stable(nn_tail_reg) && $stable(ng_tail_reg)))
        else $error("dropped push changed queue state");
`endif

endmodule

@@ tb/sv/sign_split_dual_fifo_tb.sv @@
// Testbench for sign_split_dual_fifo: directed, fill/wrap and random beats checked against a predictor.
`timescale 1ns / 1ps

module sign_split_dual_fifo_tb;
    import ssdf_pkg::*;

    localparam int QD        = QUEUE_DEPTH_DEF;
    localparam int DW        = DATA_WIDTH_DEF;
    localparam int IDLE_MAX  = 1000;  // cycles with no beat on either side
    localparam int SETTLE    = 20;    // drain time after the last result

    // opcode 3 has no package name: the block treats it as a no-op
    localparam opcode_t OP_NOP = 2'd3;

    // one output beat, unpacked from m_tdata / m_tuser
    typedef struct packed {
        logic [VALUE_W-1:0] data;
        status_t            status;
        logic               nonneg_empty;
        logic               neg_empty;
    } fifo_result_t;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [VALUE_W-1:0]   s_tdata  = '0;  // [31:0] value
    logic [S_TUSER_W-1:0] s_tuser  = '0;  // [1:0] opcode
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [VALUE_W-1:0]   m_tdata;        // [31:0] data
    logic [M_TUSER_W-1:0] m_tuser;        // [1:0] status, [2] nonneg_empty, [3] neg_empty

    // predictor state: contents of each queue, oldest first
    logic [DW-1:0] nonneg_contents[$];
    logic [DW-1:0] neg_contents[$];
    fifo_result_t  pending_results[$];

    int  mismatches = 0;
    int  idle_cycles = 0;
    bit  src_idle_en = 1'b0;
    bit  snk_idle_en = 1'b0;

    sign_split_dual_fifo i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Mostly no gap, some short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Random value; neg_pct biases bit 31, one in five is an extreme.
    function automatic logic [VALUE_W-1:0] rand_value(int neg_pct);
        logic [VALUE_W-1:0] v;
        case ($urandom_range(0, 19))
            0: v = 32'h0000_0000;
            1: v = 32'h7FFF_FFFF;
            2: v = 32'h8000_0000;
            3: v = 32'hFFFF_FFFF;
            default:
            begin
                v     = $urandom;
                v[31] = ($urandom_range(0, 99) < neg_pct);
            end
        endcase
        return v;
    endfunction

    // Queue behavior for one accepted beat: updates the contents, returns the beat.
    function automatic fifo_result_t split_fifo_step(opcode_t op, logic [VALUE_W-1:0] value);
        fifo_result_t  r;
        logic [DW-1:0] entry;
        r.data   = '0;
        r.status = ST_OK;
        case (op)
            OP_PUSH:
            begin
                // bit 31 picks the queue; zero goes with the positives
                if (value[31])
                begin
                    if (neg_contents.size() >= QD)
                        r.status = ST_FULL;
                    else
                        neg_contents.push_back(value[DW-1:0]);
                end
                else
                begin
                    if (nonneg_contents.size() >= QD)
                        r.status = ST_FULL;
                    else
                        nonneg_contents.push_back(value[DW-1:0]);
                end
            end
            OP_POP_NONNEG, OP_POP_NEG:
            begin
                if ((op == OP_POP_NONNEG ? nonneg_contents.size() : neg_contents.size()) == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    entry  = (op == OP_POP_NONNEG) ? nonneg_contents.pop_front()
                                                   : neg_contents.pop_front();
                    // sign-extend (or truncate) the stored width back to 32 bits
                    r.data = VALUE_W'($signed(entry));
                end
            end
            default: ;  // no-op
        endcase
        r.nonneg_empty = (nonneg_contents.size() == 0);
        r.neg_empty    = (neg_contents.size() == 0);
        return r;
    endfunction

    // Input side predicts, output side checks; one block keeps the order fixed.
    always @(posedge clk)
    begin
        fifo_result_t got;
        fifo_result_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                pending_results.push_back(split_fifo_step(s_tuser, s_tdata));
            if (m_tvalid && m_tready)
            begin
                got.data         = m_tdata;
                got.status       = m_tuser[1:0];
                got.nonneg_empty = m_tuser[2];
                got.neg_empty    = m_tuser[3];
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected: data %h tuser %h",
                             $time, m_tdata, m_tuser);
                    mismatches++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.data !== want.data)
                    begin
                        $display("%0t: data expected %h actual %h", $time, want.data, got.data);
                        mismatches++;
                    end
                    if (got.status !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, got.status);
                        mismatches++;
                    end
                    if (got.nonneg_empty !== want.nonneg_empty)
                    begin
                        $display("%0t: nonneg_empty expected %b actual %b",
                                 $time, want.nonneg_empty, got.nonneg_empty);
                        mismatches++;
                    end
                    if (got.neg_empty !== want.neg_empty)
                    begin
                        $display("%0t: neg_empty expected %b actual %b",
                                 $time, want.neg_empty, got.neg_empty);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Watchdog: ends the run when neither side moves for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_MAX)
        begin
            $display("sign_split_dual_fifo verification failed");
            $finish;
        end
    end

    // Result side back-pressure: random stalls when enabled.
    initial
    begin
        int g;
        forever
        begin
            @(posedge clk);
            g = snk_idle_en ? pick_gap() : 0;
            if (g > 0)
            begin
                m_tready <= 1'b0;
                repeat (g) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    // Sends one beat and returns at the edge where it is taken.
    task automatic send_beat(opcode_t op, logic [VALUE_W-1:0] value);
        int gap;
        gap = src_idle_en ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= value;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Empty pops, no-op, sign extremes, order within each queue.
    task automatic test_directed();
        src_idle_en = 1'b0;
        snk_idle_en = 1'b0;
        send_beat(OP_POP_NONNEG, 32'hFFFF_FFFF);
        send_beat(OP_POP_NEG,    32'h0000_0000);
        send_beat(OP_NOP,        32'h1234_5678);
        send_beat(OP_PUSH,       32'h0000_0000);  // zero is non-negative
        send_beat(OP_PUSH,       32'h7FFF_FFFF);
        send_beat(OP_PUSH,       32'h8000_0000);
        send_beat(OP_PUSH,       32'hFFFF_FFFF);
        send_beat(OP_PUSH,       32'h0000_0001);
        send_beat(OP_NOP,        32'hFFFF_FFFF);  // no-op with both queues holding data
        send_beat(OP_POP_NONNEG, 32'h0000_0000);
        send_beat(OP_POP_NEG,    32'hFFFF_FFFF);
        send_beat(OP_POP_NONNEG, 32'h0000_0000);
        send_beat(OP_POP_NONNEG, 32'h0000_0000);
        send_beat(OP_POP_NONNEG, 32'h0000_0000);  // now empty
        send_beat(OP_POP_NEG,    32'h0000_0000);
        send_beat(OP_POP_NEG,    32'h0000_0000);  // now empty
        send_beat(OP_NOP,        32'h0000_0000);
    endtask

    // Fill each queue past full, then drain past empty; an offset start makes
    // head and tail wrap mid-queue.
    task automatic test_fill_and_wrap(int offset);
        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;
        for (int i = 0; i < offset; i++)
        begin
            send_beat(OP_PUSH, rand_value(0));
            send_beat(OP_PUSH, rand_value(100));
        end
        for (int i = 0; i < offset; i++)
        begin
            send_beat(OP_POP_NONNEG, $urandom);
            send_beat(OP_POP_NEG, $urandom);
        end
        for (int i = 0; i < QD + 3; i++)
            send_beat(OP_PUSH, rand_value(0));
        // negative queue fills while the other one stays full
        for (int i = 0; i < QD + 3; i++)
            send_beat(OP_PUSH, rand_value(100));
        for (int i = 0; i < QD + 1; i++)
            send_beat(OP_POP_NONNEG, $urandom);
        for (int i = 0; i < QD + 1; i++)
            send_beat(OP_POP_NEG, $urandom);
    endtask

    // Episodes with their own push/pop and sign mix so the queues swing
    // between empty and full; idling switched per episode.
    task automatic test_random_mix(int beats);
        int sent;
        int len;
        int push_pct;
        int neg_pct;
        int r;
        sent = 0;
        while (sent < beats)
        begin
            len         = $urandom_range(40, 150);
            push_pct    = $urandom_range(15, 85);
            neg_pct     = $urandom_range(0, 100);
            src_idle_en = ($urandom_range(0, 3) != 0);
            snk_idle_en = ($urandom_range(0, 3) != 0);
            for (int i = 0; i < len && sent < beats; i++)
            begin
                r = $urandom_range(0, 99);
                if (r < 2)
                    send_beat(OP_NOP, $urandom);
                else if (r < push_pct)
                    send_beat(OP_PUSH, rand_value(neg_pct));
                else if ($urandom_range(0, 1))
                    send_beat(OP_POP_NONNEG, $urandom);
                else
                    send_beat(OP_POP_NEG, $urandom);
                sent++;
            end
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_fill_and_wrap(0);
        test_fill_and_wrap($urandom_range(5, QD - 5));
        test_random_mix(1050);

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (mismatches == 0)
            $display("sign_split_dual_fifo verification clean");
        else
            $display("sign_split_dual_fifo verification failed");
        $finish;
    end

endmodule
